// File: hw/rtl/hpid_pkg.sv
// Shared types, constants, microcode table and arithmetic helpers for the heading PID block.
package hpid_pkg;

   localparam int ANGLE_FRAC_BITS = 12;
   localparam int GAIN_FRAC_BITS  = 12;

   localparam int HEAD_W   = 15;
   localparam int PREV_W   = 16;
   localparam int DIFF_W   = 17;
   localparam int GAIN_W   = 16;
   localparam int RATE_W   = 32;
   localparam int MULA_W   = 17;
   localparam int PROD_W   = MULA_W + RATE_W;
   localparam int ACC_W    = 40;
   localparam int OMEGA_W  = 24;
   localparam int ETH_W    = 15;
   localparam int RTH_W    = 23;
   localparam int LRATE_W  = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 23;
   localparam int STEP_W   = 3;

   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint PI_QL  =
      (PI_Q30 + (longint'(1) << (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
   localparam logic signed [DIFF_W-1:0] PI_Q     = DIFF_W'(PI_QL);
   localparam logic signed [DIFF_W-1:0] TWO_PI_Q = DIFF_W'(2 * PI_QL);

   localparam logic signed [ACC_W-1:0] OMEGA_MAX = ACC_W'(8388607);
   localparam logic signed [ACC_W-1:0] OMEGA_MIN = ACC_W'(-8388608);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(longint'(1) << (GAIN_FRAC_BITS - 1));

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_LOOP_RATE  = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_ERR_THRESH = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_RATE_THRESH = 3'd5;

   // multiplier operand selects
   localparam logic [1:0] MUL_RATE  = 2'd0;
   localparam logic [1:0] MUL_PROP  = 2'd1;
   localparam logic [1:0] MUL_DERIV = 2'd2;
   localparam logic [1:0] MUL_INTEG = 2'd3;

   // product destinations
   localparam logic [2:0] DST_NONE     = 3'd0;
   localparam logic [2:0] DST_RATE     = 3'd1;
   localparam logic [2:0] DST_ACC_LOAD = 3'd2;
   localparam logic [2:0] DST_ACC_ADD  = 3'd3;
   localparam logic [2:0] DST_INTEG    = 3'd4;

   // jump conditions
   localparam logic [1:0] COND_NONE     = 2'd0;
   localparam logic [1:0] COND_NO_REQ   = 2'd1;
   localparam logic [1:0] COND_OUT_BUSY = 2'd2;

   // step addresses
   localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_WRAP  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_R = 3'd2;
   localparam logic [STEP_W-1:0] STEP_MUL_P = 3'd3;
   localparam logic [STEP_W-1:0] STEP_MUL_D = 3'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_I = 3'd5;
   localparam logic [STEP_W-1:0] STEP_INTEG = 3'd6;
   localparam logic [STEP_W-1:0] STEP_OUT   = 3'd7;

   typedef struct packed {
      logic              req_take;
      logic              wrap_en;
      logic              mul_en;
      logic [1:0]        mul_sel;
      logic [2:0]        dst;
      logic              out_load;
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [LRATE_W-1:0]       loop_rate;
      logic [ETH_W-1:0]         error_threshold;
      logic [RTH_W-1:0]         rate_threshold;
   } csr_type;

   function automatic ctl_type ucode_rom(input logic [STEP_W-1:0] step);
      ctl_type w;
      w = '{req_take: 1'b0, wrap_en: 1'b0, mul_en: 1'b0, mul_sel: MUL_RATE, dst: DST_NONE,
            out_load: 1'b0, cond: COND_NONE, target: STEP_WAIT};
      case (step)
         STEP_WAIT: begin
            w.req_take = 1'b1;
            w.cond     = COND_NO_REQ;
            w.target   = STEP_WAIT;
         end
         STEP_WRAP: begin
            w.wrap_en = 1'b1;
         end
         STEP_MUL_R: begin
            w.mul_en  = 1'b1;
            w.mul_sel = MUL_RATE;
         end
         STEP_MUL_P: begin
            w.mul_en  = 1'b1;
            w.mul_sel = MUL_PROP;
            w.dst     = DST_RATE;
         end
         STEP_MUL_D: begin
            w.mul_en  = 1'b1;
            w.mul_sel = MUL_DERIV;
            w.dst     = DST_ACC_LOAD;
         end
         STEP_MUL_I: begin
            w.mul_en  = 1'b1;
            w.mul_sel = MUL_INTEG;
            w.dst     = DST_ACC_ADD;
         end
         STEP_INTEG: begin
            w.dst = DST_INTEG;
         end
         STEP_OUT: begin
            w.out_load = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.target   = STEP_OUT;
         end
         default: begin
            w.cond   = COND_NONE;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

   function automatic logic signed [DIFF_W-1:0] wrap_angle(input logic signed [DIFF_W-1:0] d);
      logic signed [DIFF_W-1:0] r;
      if (d >= PI_Q)
         r = d - TWO_PI_Q;
      else if (d < -PI_Q)
         r = d + TWO_PI_Q;
      else
         r = d;
      return r;
   endfunction

   function automatic logic signed [OMEGA_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] r;
      if (x > OMEGA_MAX)
         r = OMEGA_MAX;
      else if (x < OMEGA_MIN)
         r = OMEGA_MIN;
      else
         r = x;
      return r[OMEGA_W-1:0];
   endfunction

endpackage

// File: hw/rtl/hpid_sequencer.sv
// Step counter and microcode fetch with conditional jumps.
module hpid_sequencer import hpid_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    out_busy,
   output ctl_type ctl
);

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   logic              jump;

   assign ctl = ucode_rom(pc_ff);

   always_comb begin
      jump = ((ctl.cond == COND_NO_REQ) && !req_tvalid) ||
             ((ctl.cond == COND_OUT_BUSY) && out_busy);
      pc_in = jump ? ctl.target : pc_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset)
         pc_ff <= STEP_WAIT;
      else
         pc_ff <= pc_in;
   end

   a_take_advances: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_WAIT && req_tvalid) |=> (pc_ff == STEP_WRAP))
      else $error("sequencer did not leave wait step after a beat");

endmodule

// File: hw/rtl/hpid_datapath.sv
// Shared multiplier, angle wrap, accumulator and integral state.
module hpid_datapath import hpid_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   input  csr_type                   csr,
   input  logic                      take,
   input  logic signed [HEAD_W-1:0]  meas,
   input  logic signed [HEAD_W-1:0]  targ,
   input  logic                      out_fire,
   output logic signed [OMEGA_W-1:0] omega,
   output logic                      settled
);

   logic signed [HEAD_W-1:0]  meas_ff, meas_in;
   logic signed [HEAD_W-1:0]  targ_ff, targ_in;
   logic signed [PREV_W-1:0]  prev_ff, prev_in;
   logic signed [DIFF_W-1:0]  wd_ff, wd_in;
   logic signed [DIFF_W-1:0]  err_ff, err_in;
   logic signed [RATE_W-1:0]  rate_ff, rate_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [OMEGA_W-1:0] integ_ff, integ_in;

   logic signed [MULA_W-1:0]  mul_a;
   logic signed [RATE_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  rnd_full;
   logic signed [ACC_W-1:0]   rnd;
   logic signed [ACC_W-1:0]   integ_ext;
   logic [DIFF_W-1:0]         err_mag;
   logic [RATE_W-1:0]         rate_mag;

   always_comb begin
      case (ctl.mul_sel)
         MUL_RATE: begin
            mul_a = $signed({1'b0, csr.loop_rate});
            mul_b = RATE_W'(wd_ff);
         end
         MUL_PROP: begin
            mul_a = MULA_W'(csr.prop_gain);
            mul_b = RATE_W'(err_ff);
         end
         MUL_DERIV: begin
            mul_a = MULA_W'(csr.deriv_gain);
            mul_b = rate_ff;
         end
         MUL_INTEG: begin
            mul_a = MULA_W'(csr.integ_gain);
            mul_b = RATE_W'(err_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign rnd_full  = (prod_ff + ROUND_HALF) >>> GAIN_FRAC_BITS;
   assign rnd       = rnd_full[ACC_W-1:0];
   assign integ_ext = ACC_W'(integ_ff);

   assign err_mag  = err_ff[DIFF_W-1] ? $unsigned(-err_ff) : $unsigned(err_ff);
   assign rate_mag = rate_ff[RATE_W-1] ? $unsigned(-rate_ff) : $unsigned(rate_ff);
   assign settled  = (err_mag < DIFF_W'(csr.error_threshold)) &&
                     (rate_mag < RATE_W'(csr.rate_threshold));
   assign omega    = sat24(acc_ff);

   always_comb begin
      meas_in  = take ? meas : meas_ff;
      targ_in  = take ? targ : targ_ff;
      prev_in  = prev_ff;
      wd_in    = wd_ff;
      err_in   = err_ff;
      rate_in  = rate_ff;
      acc_in   = acc_ff;
      integ_in = integ_ff;
      prod_in  = ctl.mul_en ? PROD_W'(mul_a) * PROD_W'(mul_b) : prod_ff;
      if (ctl.wrap_en) begin
         wd_in   = wrap_angle(DIFF_W'(meas_ff) - DIFF_W'(prev_ff));
         err_in  = wrap_angle(DIFF_W'(targ_ff) - DIFF_W'(meas_ff));
         prev_in = PREV_W'(meas_ff);
      end
      case (ctl.dst)
         DST_RATE:     rate_in  = prod_ff[RATE_W-1:0];
         DST_ACC_LOAD: acc_in   = integ_ext + rnd;
         DST_ACC_ADD:  acc_in   = acc_ff + rnd;
         DST_INTEG:    integ_in = sat24(integ_ext + rnd);
         default:      ;
      endcase
      if (out_fire && settled)
         integ_in = '0;
   end

   always_ff @(posedge clock) begin
      meas_ff <= meas_in;
      targ_ff <= targ_in;
      wd_ff   <= wd_in;
      err_ff  <= err_in;
      rate_ff <= rate_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         integ_ff <= integ_in;
      end
   end

   a_settle_clears: assert property (@(posedge clock) disable iff (reset)
      (out_fire && settled) |=> (integ_ff == '0))
      else $error("integral not cleared on settled beat");

endmodule

// File: hw/rtl/heading_pid_controller.sv
// Heading PID controller top level: config registers, sequencer, datapath, result register.
// Steps after an accepted req beat: WRAP, MUL_R, MUL_P, MUL_D, MUL_I, INTEG, OUT.
// One item in work at a time; the single shared 17x32 multiplier runs four products.
// A stalled rsp beat holds the sequencer in its output step until taken.
// Reset (synchronous): config registers take their defaults, previous heading and integral clear.
module heading_pid_controller import hpid_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [14:0] measured_heading, [29:15] target_heading
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OMEGA_W-1:0]  rsp_tdata,   // [23:0] omega_command
   output logic                rsp_tuser,   // [0] settled
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   csr_type                   csr_ff, csr_in;
   ctl_type                   ctl;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OMEGA_W-1:0]        omega_ff, omega_in;
   logic                      settled_ff, settled_in;
   logic signed [OMEGA_W-1:0] dp_omega;
   logic                      dp_settled;
   logic                      take;
   logic                      out_busy;
   logic                      out_fire;

   assign req_tready = ctl.req_take && !reset;
   assign take       = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign out_fire   = ctl.out_load && !out_busy;

   hpid_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_busy   (out_busy),
      .ctl        (ctl)
   );

   hpid_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .csr      (csr_ff),
      .take     (take),
      .meas     ($signed(req_tdata[HEAD_W-1:0])),
      .targ     ($signed(req_tdata[2*HEAD_W-1:HEAD_W])),
      .out_fire (out_fire),
      .omega    (dp_omega),
      .settled  (dp_settled)
   );

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PROP_GAIN:   csr_in.prop_gain       = csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:  csr_in.integ_gain      = csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:  csr_in.deriv_gain      = csr_wdata[GAIN_W-1:0];
            CSR_LOOP_RATE:   csr_in.loop_rate       = csr_wdata[LRATE_W-1:0];
            CSR_ERR_THRESH:  csr_in.error_threshold = csr_wdata[ETH_W-1:0];
            CSR_RATE_THRESH: csr_in.rate_threshold  = csr_wdata[RTH_W-1:0];
            default:         ;
         endcase
      end
      rsp_valid_in = out_fire ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      omega_in     = out_fire ? dp_omega : omega_ff;
      settled_in   = out_fire ? dp_settled : settled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.prop_gain       <= 16'sd4096;
         csr_ff.integ_gain      <= 16'sd123;
         csr_ff.deriv_gain      <= -16'sd205;
         csr_ff.loop_rate       <= 16'd100;
         csr_ff.error_threshold <= 15'd123;
         csr_ff.rate_threshold  <= 23'd410;
         rsp_valid_ff           <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      omega_ff   <= omega_in;
      settled_ff <= settled_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = omega_ff;
   assign rsp_tuser  = settled_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      take |=> !req_tready)
      else $error("second req beat accepted while an item is in work");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(out_fire))
      else $error("rsp_tvalid rose without a result load");

endmodule
